>>> hw/rtl/bounded_list_deque_top_assert.svh
// Assertion macros shared by the deque checker.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef BOUNDED_LIST_DEQUE_TOP_ASSERT_SVH
`define BOUNDED_LIST_DEQUE_TOP_ASSERT_SVH

// same-cycle implication
`define BLD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");

// next-cycle implication
`define BLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

>>> hw/rtl/bld_pkg.sv
// Shared types and codes for the bounded list deque.
// No dependencies.
package bld_pkg;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PREPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [2:0] RD_SHIFT_FIRST = 3'd0;
  localparam logic [2:0] RD_SHIFT_NEXT  = 3'd1;
  localparam logic [2:0] RD_FRONT       = 3'd2;
  localparam logic [2:0] RD_BACK        = 3'd3;
  localparam logic [2:0] RD_POS         = 3'd4;

  typedef struct packed {
    logic       load;
    logic       apply;
    logic       move;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       cap_front;
    logic       cap_back;
    logic       publish;
  } ctl_cmd_t;

  typedef struct packed {
    logic shift_req;
    logic shift_more;
    logic out_free;
  } ctl_stat_t;

endpackage

>>> hw/rtl/bld_ctrl.sv
// Command sequencer for the bounded list deque.
// Depends on bld_pkg; drives the datapath through ctl_cmd_t.
module bld_ctrl
  import bld_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctl_stat_t stat,
  output ctl_cmd_t  ctl
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_APPLY    = 3'd1;
  localparam logic [2:0] S_SH_START = 3'd2;
  localparam logic [2:0] S_SH_MOVE  = 3'd3;
  localparam logic [2:0] S_RD_FRONT = 3'd4;
  localparam logic [2:0] S_RD_BACK  = 3'd5;
  localparam logic [2:0] S_RD_POS   = 3'd6;
  localparam logic [2:0] S_PUBLISH  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        ctl.apply  = 1'b1;
        state_next = stat.shift_req ? S_SH_START : S_RD_FRONT;
      end
      S_SH_START: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_SHIFT_FIRST;
        state_next = S_SH_MOVE;
      end
      S_SH_MOVE: begin
        ctl.move = 1'b1;
        if (stat.shift_more) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_SHIFT_NEXT;
        end else begin
          state_next = S_RD_FRONT;
        end
      end
      S_RD_FRONT: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_FRONT;
        state_next = S_RD_BACK;
      end
      S_RD_BACK: begin
        ctl.cap_front = 1'b1;
        ctl.rd_en     = 1'b1;
        ctl.rd_sel    = RD_BACK;
        state_next    = S_RD_POS;
      end
      S_RD_POS: begin
        ctl.cap_back = 1'b1;
        ctl.rd_en    = 1'b1;
        ctl.rd_sel   = RD_POS;
        state_next   = S_PUBLISH;
      end
      S_PUBLISH: begin
        if (stat.out_free) begin
          ctl.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/bld_datapath.sv
// Entry memory, list pointers and result register of the bounded list deque.
// Depends on bld_pkg; steered by bld_ctrl.
module bld_datapath
  import bld_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ctl_cmd_t                   ctl,
  output ctl_stat_t                  stat,
  input  logic        [CMD_W-1:0]    command,
  input  logic signed [VALUE_W-1:0]  value_in,
  input  logic        [POS_W-1:0]    position,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic        [STATUS_W-1:0] status,
  output logic signed [VALUE_W-1:0]  read_value,
  output logic signed [VALUE_W-1:0]  front_value,
  output logic signed [VALUE_W-1:0]  back_value,
  output logic        [COUNT_W-1:0]  entry_count,
  output logic                       is_empty
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic signed [WORD_BITS-1:0] mem [CAPACITY];
  logic signed [WORD_BITS-1:0] rdata;

  logic        [CMD_W-1:0]     cmd_q;
  logic signed [WORD_BITS-1:0] val_q;
  logic        [POS_W-1:0]     pos_q;
  logic        [IW-1:0]        start;
  logic        [CW-1:0]        count;
  logic        [IW-1:0]        idx;
  logic                        rd_ok;
  logic        [STATUS_W-1:0]  status_q;
  logic signed [VALUE_W-1:0]   front_q;
  logic signed [VALUE_W-1:0]   back_q;

  logic                 full;
  logic                 pos_lt;
  logic                 pos_p1_lt;
  logic [IW-1:0]        pos_off;
  logic [IW-1:0]        back_off;
  logic [IW-1:0]        start_dec;
  logic [IW-1:0]        idx_p1;
  logic [IW-1:0]        idx_p2;
  logic [IW-1:0]        rd_addr;
  logic [IW-1:0]        wr_addr;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic [STATUS_W-1:0]  status_next;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base, input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IW+1)'(CAPACITY)) begin
      sum = sum - (IW+1)'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  assign full      = (count == CW'(CAPACITY));
  assign pos_lt    = (PW'(pos_q) < PW'(count));
  assign pos_p1_lt = (({1'b0, PW'(pos_q)} + (PW+1)'(1)) < {1'b0, PW'(count)});
  assign pos_off   = IW'(pos_q);
  assign back_off  = IW'(count - CW'(1));
  assign start_dec = (start == '0) ? IW'(CAPACITY - 1) : start - IW'(1);
  assign idx_p1    = idx + IW'(1);
  assign idx_p2    = idx + IW'(2);

  assign stat.shift_req  = (cmd_q == CMD_ERASE) && (count > CW'(1)) &&
                           (pos_q != '0) && pos_p1_lt;
  assign stat.shift_more = ((CW+1)'(idx) + (CW+1)'(1)) < (CW+1)'(count);
  assign stat.out_free   = !out_valid || !out_stall;

  always_comb begin
    unique case (ctl.rd_sel)
      RD_SHIFT_FIRST: rd_addr = slot(start, idx_p1);
      RD_SHIFT_NEXT:  rd_addr = slot(start, idx_p2);
      RD_FRONT:       rd_addr = start;
      RD_BACK:        rd_addr = slot(start, back_off);
      RD_POS:         rd_addr = slot(start, pos_off);
      default:        rd_addr = start;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot(start, idx);
    wr_data = rdata;
    if (ctl.move) begin
      wr_en = 1'b1;
    end else if (ctl.apply && !full) begin
      wr_data = val_q;
      if (cmd_q == CMD_APPEND) begin
        wr_en   = 1'b1;
        wr_addr = slot(start, IW'(count));
      end else if (cmd_q == CMD_PREPEND) begin
        wr_en   = 1'b1;
        wr_addr = start_dec;
      end
    end
  end

  always_comb begin
    case (cmd_q)
      CMD_APPEND, CMD_PREPEND: status_next = full ? ST_FULL : ST_OK;
      CMD_READ:                status_next = pos_lt ? ST_OK : ST_RANGE;
      CMD_ERASE: begin
        if (count <= CW'(1)) begin
          status_next = ST_OK;
        end else begin
          status_next = pos_lt ? ST_OK : ST_RANGE;
        end
      end
      default:                 status_next = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.apply) begin
        case (cmd_q)
          CMD_APPEND: begin
            if (!full) begin
              count <= count + CW'(1);
            end
          end
          CMD_PREPEND: begin
            if (!full) begin
              start <= start_dec;
              count <= count + CW'(1);
            end
          end
          CMD_ERASE: begin
            if (count <= CW'(1)) begin
              count <= '0;
              start <= '0;
            end else if (pos_lt) begin
              if (pos_q == '0) begin
                start <= slot(start, IW'(1));
              end
              count <= count - CW'(1);
            end
          end
          CMD_CLEAR: begin
            count <= '0;
            start <= '0;
          end
          default: ;
        endcase
      end
      if (ctl.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= command;
      val_q <= WORD_BITS'(value_in);
      pos_q <= position;
    end
    if (ctl.apply) begin
      status_q <= status_next;
      rd_ok    <= (cmd_q == CMD_READ) && pos_lt;
      idx      <= pos_off;
    end
    if (ctl.move) begin
      idx <= idx_p1;
    end
    if (ctl.cap_front) begin
      front_q <= VALUE_W'(rdata);
    end
    if (ctl.cap_back) begin
      back_q <= VALUE_W'(rdata);
    end
    if (ctl.publish) begin
      status      <= status_q;
      read_value  <= rd_ok ? VALUE_W'(rdata) : '0;
      front_value <= (count == '0) ? '0 : front_q;
      back_value  <= (count == '0) ? '0 : back_q;
      entry_count <= COUNT_W'(count);
      is_empty    <= (count == '0);
    end
  end

endmodule

>>> hw/rtl/bounded_list_deque_top.sv
// Bounded deque of signed words with positional read and erase: top level.
// Depends on bld_pkg, bld_ctrl and bld_datapath.
//
// The block works on one command at a time. in_stall is high during reset and
// from the beat that is accepted until its result is loaded into the output
// register; the result then waits there while the next command is taken. A
// command passes through the apply state, the front, back and positional reads
// and the publish state before the next accept, and waits longer while the
// previous result still waits in a stalled output register; an erase inside the
// list also closes up every entry behind the erased position, one move per
// cycle through the entry memory's single read port, which also serves the
// front, back and positional reads one after another. The entry memory needs
// no clearing pass after reset: only entries written since then reach the outputs.
module bounded_list_deque_top
  import bld_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic        [CMD_W-1:0]    command,
  input  logic signed [VALUE_W-1:0]  value_in,
  input  logic        [POS_W-1:0]    position,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic        [STATUS_W-1:0] status,
  output logic signed [VALUE_W-1:0]  read_value,
  output logic signed [VALUE_W-1:0]  front_value,
  output logic signed [VALUE_W-1:0]  back_value,
  output logic        [COUNT_W-1:0]  entry_count,
  output logic                       is_empty
);

  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  bld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  bld_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .command     (command),
    .value_in    (value_in),
    .position    (position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .read_value  (read_value),
    .front_value (front_value),
    .back_value  (back_value),
    .entry_count (entry_count),
    .is_empty    (is_empty)
  );

endmodule

>>> hw/rtl/bld_checker.sv
// Port-level checks for bounded_list_deque_top, attached by bind.
// Depends on bld_pkg and bounded_list_deque_top_assert.svh.
`include "bounded_list_deque_top_assert.svh"

module bld_checker
  import bld_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic        [STATUS_W-1:0] status,
  input logic signed [VALUE_W-1:0]  read_value,
  input logic signed [VALUE_W-1:0]  front_value,
  input logic signed [VALUE_W-1:0]  back_value,
  input logic        [COUNT_W-1:0]  entry_count,
  input logic                       is_empty
);

  logic [STATUS_W+3*VALUE_W+COUNT_W:0] out_word;
  logic                                shown_zero;

  assign out_word   = {status, read_value, front_value, back_value, entry_count, is_empty};
  assign shown_zero = ({front_value, back_value, entry_count} == '0);

  `BLD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  `BLD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `BLD_ASSERT_IMP(a_empty_zero, out_valid && is_empty, shown_zero)
  `BLD_ASSERT_IMP(a_fail_no_read, out_valid && status != ST_OK, read_value == '0)

endmodule

bind bounded_list_deque_top bld_checker u_bld_checker (.*);
